[src/assert_macros.svh]
// Assertion helpers for the stepper positioner RTL.
// Expects the including module to provide aclk and active-low aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked every clock outside reset.
`define SSPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Implication: when ante holds, cons must hold on the same edge.
`define SSPP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[src/sspp_pkg.sv]
// Package for the stepper shortest-path positioner: command codes, phase table,
// angle reduction constants and the speed-to-delay table builder. No dependencies.
`default_nettype none

package sspp_pkg;

    // Command kinds carried on s_tuser
    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_SET_ANGLE  = 2'd1,
        CMD_DEACTIVATE = 2'd2
    } cmd_t;

    localparam int unsigned STEPS_PER_REV_DEF = 2048;
    localparam int unsigned MIN_DELAY_DEF     = 5;
    localparam int unsigned MAX_DELAY_DEF     = 20;

    localparam int unsigned DLY_W       = 5;
    localparam int unsigned SPEED_MAX   = 100;
    localparam int unsigned SPEED_SCALE = 10000;
    localparam int unsigned DEG_PER_REV = 360;

    // Angle reduction: u = angle + ANG_OFFSET is non-negative (17 bits),
    // u / 360 is exact as (u * MOD_RECIP) >> MOD_SHIFT over that range.
    localparam int unsigned ANG_W      = 16;
    localparam int unsigned U_W        = 17;
    localparam int unsigned ANG_OFFSET = 33120;
    localparam int unsigned MOD_RECIP  = 93207;
    localparam int unsigned MOD_SHIFT  = 25;
    localparam int unsigned QUO_W      = 8;
    localparam int unsigned DEG_W      = 9;

    // Degrees-to-steps scaling shift; recip derived from steps per turn
    localparam int unsigned TGT_SHIFT = 18;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_REV = 1'b1;

    typedef logic [3:0] coil_t;
    localparam coil_t PHASE_COILS [4] = '{4'h3, 4'h6, 4'hC, 4'h9};

    typedef logic [DLY_W-1:0] dly_tab_t [0:SPEED_MAX];

    // Step delay per distance-from-full-speed d = 100 - speed
    function automatic dly_tab_t build_dly_tab(input int unsigned min_d,
                                               input int unsigned max_d);
        dly_tab_t    tab;
        int unsigned rng;
        rng = (max_d > min_d) ? (max_d - min_d) : 0;
        for (int unsigned i = 0; i <= SPEED_MAX; i++) begin
            tab[i] = DLY_W'(min_d + (rng * i * i) / SPEED_SCALE);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

[src/stepper_shortest_path_positioner_core.sv]
// Top level of the stepper shortest-path positioner: command pipeline, move
// state and result register. Depends on sspp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Stepper positioner. Each s_ transaction is one command (tick, set angle,
// deactivate); each one produces exactly one m_ transaction reporting coils,
// position and busy after the command. Throughput is one transaction per clock
// while the result register is not held; the angle pipeline has four stages
// (input register, reciprocal divide by 360, remainder, degrees-to-steps scale)
// ahead of the motion state update and result register. The whole
// pipeline advances whenever the result register is empty or being taken, so
// s_tready = !m_tvalid || m_tready. Set angle picks the shorter way round
// (ties go to target minus position), steps once at once, and then steps once
// per step_delay ticks; step_delay falls quadratically from MAX_DELAY at
// speed 0 to MIN_DELAY at speed 100 and above. Deactivate stops and powers
// the coils down, keeping the position.
module stepper_shortest_path_positioner_core #(
    parameter int unsigned STEPS_PER_REV = sspp_pkg::STEPS_PER_REV_DEF,
    parameter int unsigned MIN_DELAY     = sspp_pkg::MIN_DELAY_DEF,
    parameter int unsigned MAX_DELAY     = sspp_pkg::MAX_DELAY_DEF,
    localparam int unsigned POS_W        = $clog2(STEPS_PER_REV),
    localparam int unsigned M_TDATA_W    = ((POS_W + 5 + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,   // [15:0] angle (signed), [23:16] speed
    input  wire logic [1:0]           s_tuser,   // [1:0] cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // coils[3:0], position, busy_res, zero pad
);
    import sspp_pkg::*;

    localparam int unsigned TGT_RECIP =
        ((STEPS_PER_REV << TGT_SHIFT) + DEG_PER_REV - 1) / DEG_PER_REV;
    localparam int unsigned TGT_RECIP_W = $clog2(TGT_RECIP + 1);
    localparam int unsigned TGT_PROD_W  = DEG_W + TGT_RECIP_W;
    localparam int unsigned MOD_PROD_W  = 2 * U_W;
    localparam int unsigned BUSY_BIT    = 4 + POS_W;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(STEPS_PER_REV - 1);
    localparam dly_tab_t DLY_TAB = build_dly_tab(MIN_DELAY, MAX_DELAY);

    // ---------------- pipeline control ----------------
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            m_tvalid_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    cmd_t                   cmd1_reg;
    logic signed [ANG_W-1:0] ang1_reg;
    logic [7:0]             spd1_reg;

    // ---------------- stage 1 -> 2: offset, divide by 360, delay lookup ----
    logic [U_W-1:0]        u1;
    logic [MOD_PROD_W-1:0] mod_prod;
    logic [7:0]            spd_clamp;
    logic [6:0]            spd_gap;

    assign u1        = U_W'($signed({ang1_reg[ANG_W-1], ang1_reg})) + U_W'(ANG_OFFSET);
    assign mod_prod  = MOD_PROD_W'(u1) * MOD_PROD_W'(MOD_RECIP);
    assign spd_clamp = (spd1_reg > 8'(SPEED_MAX)) ? 8'(SPEED_MAX) : spd1_reg;
    assign spd_gap   = 7'(8'(SPEED_MAX) - spd_clamp);

    cmd_t             cmd2_reg;
    logic [U_W-1:0]   u2_reg;
    logic [QUO_W-1:0] q2_reg;
    logic [DLY_W-1:0] dly2_reg;

    // ---------------- stage 2 -> 3: remainder in degrees ----------------
    logic [U_W-1:0] deg_full;
    assign deg_full = u2_reg - U_W'(q2_reg) * U_W'(DEG_PER_REV);

    cmd_t             cmd3_reg;
    logic [DEG_W-1:0] deg3_reg;
    logic [DLY_W-1:0] dly3_reg;

    // ---------------- stage 3 -> 4: degrees to target step ----------------
    logic [TGT_PROD_W-1:0] tgt_prod;
    assign tgt_prod = TGT_PROD_W'(deg3_reg) * TGT_PROD_W'(TGT_RECIP);

    cmd_t             cmd4_reg;
    logic [POS_W-1:0] tgt4_reg;
    logic [DLY_W-1:0] dly4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg <= cmd_t'(s_tuser);
            ang1_reg <= s_tdata[15:0];
            spd1_reg <= s_tdata[23:16];

            cmd2_reg <= cmd1_reg;
            u2_reg   <= u1;
            q2_reg   <= QUO_W'(mod_prod >> MOD_SHIFT);
            dly2_reg <= DLY_TAB[spd_gap];

            cmd3_reg <= cmd2_reg;
            deg3_reg <= deg_full[DEG_W-1:0];
            dly3_reg <= dly2_reg;

            cmd4_reg <= cmd3_reg;
            tgt4_reg <= POS_W'(tgt_prod >> TGT_SHIFT);
            dly4_reg <= dly3_reg;
        end
    end

    // ---------------- motion state ----------------
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [POS_W-1:0] rem_reg,   rem_next;
    logic             dir_reg,   dir_next;
    logic [DLY_W-1:0] dc_reg,    dc_next;
    logic [DLY_W-1:0] sdly_reg,  sdly_next;
    coil_t            coils_reg, coils_next;

    function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p,
                                                  input logic d);
        logic [POS_W-1:0] r;
        if (d == DIR_FWD) begin
            r = (p == POS_LAST) ? '0 : p + 1'b1;
        end else begin
            r = (p == '0) ? POS_LAST : p - 1'b1;
        end
        return r;
    endfunction

    // Shortest-path choice: direct distance vs. the way round
    logic             tgt_ge;
    logic [POS_W-1:0] mv_abs;
    logic [POS_W:0]   mv_alt;
    logic             mv_direct;
    logic             mv_dir;
    logic [POS_W-1:0] mv_len;
    logic [DLY_W-1:0] tick_dc;

    assign tgt_ge    = tgt4_reg >= pos_reg;
    assign mv_abs    = tgt_ge ? (tgt4_reg - pos_reg) : (pos_reg - tgt4_reg);
    assign mv_alt    = (POS_W + 1)'(STEPS_PER_REV) - {1'b0, mv_abs};
    assign mv_direct = {1'b0, mv_abs} <= mv_alt;
    assign mv_dir    = (mv_direct == tgt_ge) ? DIR_FWD : DIR_REV;
    assign mv_len    = mv_direct ? mv_abs : mv_alt[POS_W-1:0];
    assign tick_dc   = dc_reg - 1'b1;

    always_comb begin
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        dir_next   = dir_reg;
        dc_next    = dc_reg;
        sdly_next  = sdly_reg;
        coils_next = coils_reg;
        case (cmd4_reg)
            CMD_TICK: begin
                if (dc_reg != '0) begin
                    dc_next = tick_dc;
                    // delay expired with steps left: step and reload
                    if (tick_dc == '0 && rem_reg != '0) begin
                        pos_next   = step_pos(pos_reg, dir_reg);
                        coils_next = PHASE_COILS[pos_next[1:0]];
                        rem_next   = rem_reg - 1'b1;
                        dc_next    = sdly_reg;
                    end
                end
            end
            CMD_SET_ANGLE: begin
                if (tgt4_reg == pos_reg) begin
                    // already there: drop any move, keep coils
                    rem_next = '0;
                    dc_next  = '0;
                end else begin
                    dir_next   = mv_dir;
                    sdly_next  = dly4_reg;
                    pos_next   = step_pos(pos_reg, mv_dir);
                    coils_next = PHASE_COILS[pos_next[1:0]];
                    rem_next   = mv_len - 1'b1;
                    dc_next    = dly4_reg;
                end
            end
            CMD_DEACTIVATE: begin
                rem_next   = '0;
                dc_next    = '0;
                coils_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            rem_reg   <= '0;
            dir_reg   <= DIR_FWD;
            dc_reg    <= '0;
            sdly_reg  <= DLY_W'(MIN_DELAY);
            coils_reg <= '0;
        end else if (en && v4_reg) begin
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            dir_reg   <= dir_next;
            dc_reg    <= dc_next;
            sdly_reg  <= sdly_next;
            coils_reg <= coils_next;
        end
    end

    // ---------------- result register ----------------
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (en && v4_reg) begin
            m_tdata_reg <= M_TDATA_W'({(rem_next != '0) || (dc_next != '0),
                                       pos_next, coils_next});
        end
    end

    assign m_tdata = m_tdata_reg;

    // ---------------- assertions ----------------
    `SSPP_ASSERT_IMP(a_steps_need_delay, rem_reg != '0, dc_reg != '0, "steps left but no delay running")
    `SSPP_ASSERT_IMP(a_coils_match_pos, coils_reg != '0, coils_reg == PHASE_COILS[pos_reg[1:0]], "coil pattern out of phase with position")
    `SSPP_ASSERT_IMP(a_result_matches_state, m_tvalid_reg, (m_tdata_reg[BUSY_BIT] == ((rem_reg != '0) || (dc_reg != '0))) && (m_tdata_reg[BUSY_BIT-1:4] == pos_reg), "result out of step with motion state")

endmodule

`default_nettype wire

[verif/tb.sv]
// Testbench for stepper_shortest_path_positioner_core: directed command cases, then random
// move/tick traffic under several handshake idling phases, checked against a local predictor.
// Depends on sspp_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
    import sspp_pkg::*;

    localparam int STEPS      = int'(STEPS_PER_REV_DEF);
    localparam int DLY_MIN    = int'(MIN_DELAY_DEF);
    localparam int DLY_MAX    = int'(MAX_DELAY_DEF);
    localparam int DEG        = int'(DEG_PER_REV);
    localparam int SPD_TOP    = int'(SPEED_MAX);
    localparam int SPD_SCALE  = int'(SPEED_SCALE);
    localparam int POS_W      = $clog2(STEPS);
    localparam int RES_W      = ((POS_W + 5 + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;   // cycles with no transaction on either side
    localparam int SETTLE_CYCLES = 20;   // extra wait after the queue drains, well past the pipeline latency

    // Command code with no meaning; the core must ignore it
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    // Full-step drive sequence indexed by position mod 4
    localparam logic [3:0] STEP_PATTERN [4] = '{4'h3, 4'h6, 4'hC, 4'h9};

    typedef struct packed {
        logic [3:0]       coils;
        logic [POS_W-1:0] position;
        logic             busy;
    } motor_status_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [23:0]      s_tdata = '0;     // [15:0] angle (signed), [23:16] speed
    logic [1:0]       s_tuser = '0;     // [1:0] cmd
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [RES_W-1:0] m_tdata;          // [3:0] coils, [14:4] position, [15] busy

    // Predicted motor state
    logic [POS_W-1:0] pos_q;
    logic [POS_W-1:0] steps_left;
    logic             dir_q;
    logic [4:0]       tick_cnt;
    logic [4:0]       tick_reload;
    logic [3:0]       coil_q;

    motor_status_t status_q[$];
    int            err_cnt = 0;
    int            cmd_cnt = 0;
    int            idle_cycles = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    stepper_shortest_path_positioner_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    function automatic logic [4:0] speed_to_delay(input logic [7:0] spd);
        int s;
        int d;
        int span;
        s = (int'(spd) > SPD_TOP) ? SPD_TOP : int'(spd);
        d = SPD_TOP - s;
        span = (DLY_MAX > DLY_MIN) ? (DLY_MAX - DLY_MIN) : 0;
        return 5'(DLY_MIN + (span * d * d) / SPD_SCALE);
    endfunction

    function automatic void step_motor();
        if (dir_q == DIR_FWD) begin
            pos_q = (int'(pos_q) + 1 >= STEPS) ? '0 : pos_q + 1'b1;
        end else begin
            pos_q = (pos_q == 0) ? POS_W'(STEPS - 1) : pos_q - 1'b1;
        end
        coil_q = STEP_PATTERN[pos_q[1:0]];
    endfunction

    function automatic void reset_motor();
        pos_q       = '0;
        steps_left  = '0;
        dir_q       = DIR_FWD;
        tick_cnt    = '0;
        tick_reload = 5'(DLY_MIN);
        coil_q      = '0;
    endfunction

    function automatic motor_status_t apply_command(input logic [1:0] cmd,
                                                    input logic [15:0] ang,
                                                    input logic [7:0] spd);
        motor_status_t r;
        int a;
        int tgt;
        int delta;
        int alt;
        int ad;
        int aa;
        int best;
        case (cmd)
            CMD_TICK: begin
                if (tick_cnt != 0) begin
                    tick_cnt = tick_cnt - 1'b1;
                    if (tick_cnt == 0 && steps_left != 0) begin
                        step_motor();
                        steps_left = steps_left - 1'b1;
                        tick_cnt   = tick_reload;
                    end
                end
            end
            CMD_SET_ANGLE: begin
                a   = int'($signed(ang));
                a   = ((a % DEG) + DEG) % DEG;
                tgt = (STEPS * a) / DEG;
                if (tgt == int'(pos_q)) begin
                    // already there: drop whatever move was running
                    steps_left = '0;
                    tick_cnt   = '0;
                end else begin
                    delta = tgt - int'(pos_q);
                    alt   = (delta > 0) ? delta - STEPS : delta + STEPS;
                    ad    = (delta < 0) ? -delta : delta;
                    aa    = (alt < 0) ? -alt : alt;
                    best  = (ad <= aa) ? delta : alt;   // tie keeps the direct delta
                    dir_q = (best > 0) ? DIR_FWD : DIR_REV;
                    tick_reload = speed_to_delay(spd);
                    step_motor();
                    steps_left = POS_W'(((best < 0) ? -best : best) - 1);
                    tick_cnt   = tick_reload;
                end
            end
            CMD_DEACTIVATE: begin
                steps_left = '0;
                tick_cnt   = '0;
                coil_q     = '0;
            end
            default: ;
        endcase
        r.coils    = coil_q;
        r.position = pos_q;
        r.busy     = (steps_left != 0) || (tick_cnt != 0);
        return r;
    endfunction

    // ---------------- drivers ----------------

    // Sink side: random backpressure per cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one command; returns right after the accepting edge.
    task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] ang,
                            input logic [7:0] spd);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {spd, ang};
        do @(posedge aclk); while (!s_tready);
        status_q.push_back(apply_command(cmd, ang, spd));
        if (cmd != CMD_RESERVED) cmd_cnt++;
    endtask

    // Drop tvalid so the last transaction is not taken twice while we wait
    task automatic release_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // ---------------- result checking ----------------

    always @(posedge aclk) begin : result_check
        motor_status_t want;
        motor_status_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.coils    = m_tdata[3:0];
            got.position = m_tdata[4 +: POS_W];
            got.busy     = m_tdata[4 + POS_W];
            if (status_q.size() == 0) begin
                $error("result with nothing pending: coils %h position %0d busy %0d",
                       got.coils, got.position, got.busy);
                err_cnt++;
            end else begin
                want = status_q.pop_front();
                if (got.coils !== want.coils) begin
                    $error("coils: expected %h, got %h", want.coils, got.coils);
                    err_cnt++;
                end
                if (got.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, got.position);
                    err_cnt++;
                end
                if (got.busy !== want.busy) begin
                    $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- tests ----------------

    // Ticks and the reserved code from reset, then a set angle onto the current spot
    task automatic test_idle_commands();
        send_cmd(CMD_TICK, 16'h0000, 8'h00);
        send_cmd(CMD_RESERVED, 16'hFFFF, 8'hFF);
        send_cmd(CMD_SET_ANGLE, 16'd0, 8'd0);
    endtask

    // Half a turn away is a tie: goes forward by the direct delta; then power down
    task automatic test_tie_and_deactivate();
        send_cmd(CMD_SET_ANGLE, 16'd180, 8'd255);
        send_cmd(CMD_TICK, 16'h0000, 8'h00);
        send_cmd(CMD_DEACTIVATE, 16'h8000, 8'h80);
        send_cmd(CMD_TICK, 16'hFFFF, 8'hFF);
    endtask

    // Angle extremes, speed clamp and slowest speed; each set replaces the last move
    task automatic test_angle_extremes();
        send_cmd(CMD_SET_ANGLE, 16'h8000, 8'd0);
        send_cmd(CMD_TICK, 16'h0000, 8'h00);
        send_cmd(CMD_SET_ANGLE, 16'h7FFF, 8'd100);
        send_cmd(CMD_SET_ANGLE, 16'hFFFF, 8'd50);
        send_cmd(CMD_SET_ANGLE, 16'd1, 8'd101);
        send_cmd(CMD_RESERVED, 16'h1234, 8'h56);
    endtask

    // Reach the target with the final delay running, then ask for it again
    task automatic test_target_reached();
        send_cmd(CMD_SET_ANGLE, 16'd0, 8'd100);
        send_cmd(CMD_SET_ANGLE, 16'd0, 8'd100);
        send_cmd(CMD_SET_ANGLE, 16'd1, 8'd100);
        send_cmd(CMD_TICK, 16'h0000, 8'h00);
        send_cmd(CMD_TICK, 16'h0000, 8'h00);
        send_cmd(CMD_SET_ANGLE, 16'd0, 8'd100);
        send_cmd(CMD_SET_ANGLE, 16'd0, 8'd100);
    endtask

    function automatic logic [7:0] pick_speed();
        return ($urandom_range(1) != 0) ? 8'($urandom_range(255, 90)) : 8'($urandom_range(255));
    endfunction

    // Angle a few degrees from the current position, wrapped by a random number of turns
    function automatic logic [15:0] nearby_angle();
        int off;
        int turns;
        off = $urandom_range(6);
        off -= 3;
        turns = $urandom_range(180);
        turns -= 90;
        return 16'((int'(pos_q) * DEG) / STEPS + off + DEG * turns);
    endfunction

    // Mostly short moves followed by tick bursts; bursts are cut at the phase's count
    task automatic test_random_traffic(input int n_cmds);
        int goal;
        int pick;
        int burst;
        goal = cmd_cnt + n_cmds;
        while (cmd_cnt < goal) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                send_cmd(CMD_SET_ANGLE, nearby_angle(), pick_speed());
                burst = $urandom_range(80, 1);
                if (burst > goal - cmd_cnt) burst = goal - cmd_cnt;
                repeat (burst) send_cmd(CMD_TICK, 16'($urandom), 8'($urandom));
            end else if (pick < 75) begin
                send_cmd(CMD_SET_ANGLE, 16'($urandom), 8'($urandom));
                burst = $urandom_range(20, 1);
                if (burst > goal - cmd_cnt) burst = goal - cmd_cnt;
                repeat (burst) send_cmd(CMD_TICK, 16'($urandom), 8'($urandom));
            end else if (pick < 85) begin
                send_cmd(CMD_DEACTIVATE, 16'($urandom), 8'($urandom));
            end else if (pick < 90) begin
                send_cmd(CMD_RESERVED, 16'($urandom), 8'($urandom));
            end else begin
                send_cmd(CMD_TICK, 16'($urandom), 8'($urandom));
            end
        end
    endtask

    // Sender holds off until every outstanding result has been returned
    task automatic test_drain_pause();
        release_input();
        while (status_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        reset_motor();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_commands();
        test_tie_and_deactivate();
        test_angle_extremes();
        test_target_reached();

        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_traffic(112);
        send_idle_pct = 63; recv_stall_pct = 0;
        test_random_traffic(112);
        test_drain_pause();
        send_idle_pct = 0;  recv_stall_pct = 63;
        test_random_traffic(112);
        send_idle_pct = 21; recv_stall_pct = 21;
        test_random_traffic(112);

        release_input();
        while (status_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
